// ===== rtl/bafd_pkg.sv =====
`default_nettype none
package bafd_pkg;

	typedef enum logic {
		REG_STEP_RATIO    = 1'b0,
		REG_INVERSE_RATIO = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic restart;
		logic emit;
	} item_ctl_t;

	localparam int unsigned RATIO_INT_BITS = 8;
	localparam int unsigned QUEUE_DEPTH    = 4;

endpackage
`default_nettype wire

// ===== rtl/bafd_front.sv =====
`default_nettype none
module bafd_front import bafd_pkg::*; #(
	parameter int unsigned SAMPLE_BITS   = 16,
	parameter int unsigned FRACTION_BITS = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic [FRACTION_BITS+RATIO_INT_BITS-1:0]   step_ratio,
	input  wire logic                                      in_valid,
	output logic                                           in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]             sample,
	input  wire logic                                      restart,
	output logic                                           item_valid,
	input  wire logic                                      item_ready,
	output item_ctl_t                                      item_ctl,
	output logic signed [SAMPLE_BITS-1:0]                  item_sample,
	output logic [FRACTION_BITS:0]                         item_w_a,
	output logic [FRACTION_BITS:0]                         item_w_b
);

	localparam int unsigned STEP_W = FRACTION_BITS + RATIO_INT_BITS;
	localparam int unsigned WT_W   = FRACTION_BITS + 1;
	localparam logic [STEP_W-1:0] ONE        = STEP_W'(1) << FRACTION_BITS;
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(2) << FRACTION_BITS;

	logic [STEP_W-1:0] d_q;
	logic [STEP_W-1:0] eff_step;
	logic [STEP_W-1:0] d_cur;
	logic [STEP_W-1:0] d_rem;
	logic [STEP_W-1:0] d_nxt;
	logic              at_boundary;

	always_comb begin
		eff_step    = (step_ratio < ONE) ? ONE : step_ratio;
		d_cur       = restart ? eff_step : d_q;
		at_boundary = (d_cur <= ONE);
		d_rem       = ONE - d_cur;
		item_ctl.restart = restart;
		item_ctl.emit    = at_boundary;
		if (at_boundary) begin
			item_w_a = d_cur[WT_W-1:0];
			item_w_b = d_rem[WT_W-1:0];
			d_nxt    = eff_step - d_rem;
		end else begin
			item_w_a = ONE[WT_W-1:0];
			item_w_b = '0;
			d_nxt    = d_cur - ONE;
		end
	end

	assign item_valid  = in_valid;
	assign in_ready    = item_ready;
	assign item_sample = sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= STEP_RESET;
		end else if (in_valid && in_ready) begin
			d_q <= d_nxt;
		end
	end

	// split weights of a boundary sample add up to one unit
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ctl.emit |->
			(({1'b0, item_w_a} + {1'b0, item_w_b}) == ONE[WT_W:0]))
		else $error("boundary weights do not sum to one");

	assert property (@(posedge clk) disable iff (!arst_n) d_q != '0)
		else $error("boundary distance reached zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !item_ctl.emit |=> d_q == $past(d_cur) - ONE)
		else $error("phase did not advance by one unit");

endmodule
`default_nettype wire

// ===== rtl/bafd_queue.sv =====
`default_nettype none
module bafd_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(DEPTH))
		else $error("queue count overflow");

endmodule
`default_nettype wire

// ===== rtl/bafd_back.sv =====
`default_nettype none
module bafd_back import bafd_pkg::*; #(
	parameter int unsigned SAMPLE_BITS   = 16,
	parameter int unsigned FRACTION_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [FRACTION_BITS:0]        inverse_ratio,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire item_ctl_t                     item_ctl,
	input  wire logic signed [SAMPLE_BITS-1:0] item_sample,
	input  wire logic [FRACTION_BITS:0]        item_w_a,
	input  wire logic [FRACTION_BITS:0]        item_w_b,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      average
);

	localparam int unsigned WT_W   = FRACTION_BITS + 1;
	localparam int unsigned INV_W  = FRACTION_BITS + 1;
	localparam int unsigned PROD_W = SAMPLE_BITS + WT_W + 1;
	localparam int unsigned SUM_W  = SAMPLE_BITS + FRACTION_BITS + RATIO_INT_BITS + 2;
	localparam int unsigned NRM_W  = SUM_W + INV_W;
	localparam int unsigned RND_W  = NRM_W + 1;
	localparam int unsigned Q_W    = RND_W - 2 * FRACTION_BITS;
	localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (2 * FRACTION_BITS - 1);
	localparam logic [Q_W-1:0]   LIM_NEG  = Q_W'(1) << (SAMPLE_BITS - 1);
	localparam logic [Q_W-1:0]   LIM_POS  = LIM_NEG - 1'b1;

	// s1: weighted products
	logic                     v_s1;
	item_ctl_t                ctl_s1;
	logic signed [PROD_W-1:0] prod_a_s1;
	logic signed [PROD_W-1:0] prod_b_s1;
	// s2: completed span sum
	logic                     v_s2;
	logic signed [SUM_W-1:0]  tot_s2;
	logic signed [SUM_W-1:0]  sum_q;
	// s3: magnitude
	logic                     v_s3;
	logic                     neg_s3;
	logic [SUM_W-1:0]         mag_s3;
	// s4: normalized product
	logic                     v_s4;
	logic                     neg_s4;
	logic [NRM_W-1:0]         prod_s4;
	// output register
	logic                     out_valid_q;
	logic signed [SAMPLE_BITS-1:0] average_q;

	logic                     adv1, adv2, adv3, adv4, load1;
	logic signed [SUM_W-1:0]  acc;
	logic [RND_W-1:0]         rnd;
	logic [Q_W-1:0]           q;
	logic [Q_W-1:0]           q_clip;
	logic signed [SAMPLE_BITS-1:0] avg_nxt;

	always_comb begin
		adv4  = v_s4 && (!out_valid_q || out_ready);
		adv3  = v_s3 && (!v_s4 || adv4);
		adv2  = v_s2 && (!v_s3 || adv3);
		adv1  = v_s1 && (!ctl_s1.emit || !v_s2 || adv2);
		item_ready = !v_s1 || adv1;
		load1 = item_valid && item_ready;
		acc   = (ctl_s1.restart ? SUM_W'(0) : sum_q) + SUM_W'(prod_a_s1);
		rnd   = {1'b0, prod_s4} + RND_HALF;
		q     = rnd[RND_W-1:2*FRACTION_BITS];
		if (neg_s4) begin
			q_clip  = (q > LIM_NEG) ? LIM_NEG : q;
			avg_nxt = -q_clip[SAMPLE_BITS-1:0];
		end else begin
			q_clip  = (q > LIM_POS) ? LIM_POS : q;
			avg_nxt = q_clip[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			ctl_s1    <= item_ctl;
			prod_a_s1 <= item_sample * $signed({1'b0, item_w_a});
			prod_b_s1 <= item_sample * $signed({1'b0, item_w_b});
		end
		if (adv1 && ctl_s1.emit) begin
			tot_s2 <= acc;
		end
		if (adv2) begin
			neg_s3 <= tot_s2[SUM_W-1];
			mag_s3 <= tot_s2[SUM_W-1] ? SUM_W'(-tot_s2) : SUM_W'(tot_s2);
		end
		if (adv3) begin
			neg_s4  <= neg_s3;
			prod_s4 <= mag_s3 * inverse_ratio;
		end
		if (adv4) begin
			average_q <= avg_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			sum_q       <= '0;
		end else begin
			if (adv1) begin
				sum_q <= ctl_s1.emit ? SUM_W'(prod_b_s1) : acc;
			end
			if (load1) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1 && ctl_s1.emit) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				v_s3 <= 1'b1;
			end else if (adv3) begin
				v_s3 <= 1'b0;
			end
			if (adv3) begin
				v_s4 <= 1'b1;
			end else if (adv4) begin
				v_s4 <= 1'b0;
			end
			if (adv4) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;

	// a span sum spans at most 256 units of full-scale samples
	assert property (@(posedge clk) disable iff (!arst_n) v_s3 |-> !mag_s3[SUM_W-1])
		else $error("span sum magnitude overflow");

	assert property (@(posedge clk) disable iff (!arst_n) $rose(out_valid) |-> $past(v_s4))
		else $error("result appeared without a normalized sum");

endmodule
`default_nettype wire

// ===== rtl/box_average_fractional_decimator.sv =====
`default_nettype none
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    sample, restart
// out      output     out_valid / out_ready  average
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// One input transfer per cycle sustained while out_ready holds; after its boundary
// sample, a result passes queue, product, accumulate, magnitude, normalize, output.
// The phase register in the front sets the one-per-cycle figure.
// Reset clears the phase to 2.0 units, the span sum to zero and all valid flags.
// A stalled output fills the back stages, then the four-entry queue, then drops in_ready.
module box_average_fractional_decimator import bafd_pkg::*; #(
	parameter int unsigned SAMPLE_BITS   = 16,
	parameter int unsigned FRACTION_BITS = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]           sample,
	input  wire logic                                    restart,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output logic signed [SAMPLE_BITS-1:0]                average,
	input  wire logic                                    cfg_we,
	input  wire logic                                    cfg_index,
	input  wire logic [FRACTION_BITS+RATIO_INT_BITS-1:0] cfg_data
);

	localparam int unsigned STEP_W = FRACTION_BITS + RATIO_INT_BITS;
	localparam int unsigned INV_W  = FRACTION_BITS + 1;
	localparam int unsigned WT_W   = FRACTION_BITS + 1;
	localparam int unsigned ENT_W  = $bits(item_ctl_t) + SAMPLE_BITS + 2 * WT_W;
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(2) << FRACTION_BITS;
	localparam logic [INV_W-1:0]  INV_RESET  = INV_W'(1) << (FRACTION_BITS - 1);

	logic [STEP_W-1:0] step_ratio_q;
	logic [INV_W-1:0]  inverse_ratio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ratio_q    <= STEP_RESET;
			inverse_ratio_q <= INV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_RATIO:    step_ratio_q    <= cfg_data;
				REG_INVERSE_RATIO: inverse_ratio_q <= cfg_data[INV_W-1:0];
				default:           ;
			endcase
		end
	end

	logic                          f_valid, f_ready;
	item_ctl_t                     f_ctl;
	logic signed [SAMPLE_BITS-1:0] f_sample;
	logic [WT_W-1:0]               f_w_a, f_w_b;

	logic                          b_valid, b_ready;
	item_ctl_t                     b_ctl;
	logic signed [SAMPLE_BITS-1:0] b_sample;
	logic [WT_W-1:0]               b_w_a, b_w_b;
	logic [ENT_W-1:0]              q_push_data, q_pop_data;

	bafd_front #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_ratio  (step_ratio_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.restart     (restart),
		.item_valid  (f_valid),
		.item_ready  (f_ready),
		.item_ctl    (f_ctl),
		.item_sample (f_sample),
		.item_w_a    (f_w_a),
		.item_w_b    (f_w_b)
	);

	assign q_push_data = {f_ctl, f_sample, f_w_a, f_w_b};

	bafd_queue #(
		.WIDTH (ENT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (q_push_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (q_pop_data)
	);

	assign {b_ctl, b_sample, b_w_a, b_w_b} = q_pop_data;

	bafd_back #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.inverse_ratio (inverse_ratio_q),
		.item_valid    (b_valid),
		.item_ready    (b_ready),
		.item_ctl      (b_ctl),
		.item_sample   (b_sample),
		.item_w_a      (b_w_a),
		.item_w_b      (b_w_b),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.average       (average)
	);

endmodule
`default_nettype wire
